// ===== src/smed_pkg.sv =====
// smed_pkg: shared types and constants for the sample median block.
// Beat payload structs, controller/datapath command and status groups.
// No dependencies.
`timescale 1ns / 1ps

package smed_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 7;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic                     last;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] median_value;
		logic [COUNT_W-1:0]       sample_count;
		logic                     overflow;
	} result_t;

	typedef struct packed {
		logic load;     // capture input beat, position at top of store
		logic drop;     // store full, flag overflow
		logic rd_prev;  // read entry below insertion point
		logic shift;    // move that entry up one place
		logic place;    // write sample at insertion point
		logic rd_hi;    // read upper middle entry
		logic rd_lo;    // latch upper, read lower middle entry
		logic finish;   // form result, empty store
	} cmd_t;

	typedef struct packed {
		logic full;
		logic idx_zero;
		logic gt;
		logic last;
	} status_t;

endpackage

// ===== src/sample_median.sv =====
// Sample median: insertion-sorted store, median on the beat marked last.
// Per beat, busy holds while each stored entry greater than the sample is read and moved up
// one place, and then the sample is written; a full store drops the sample and flags overflow.
// A last beat then reads the two middle entries and forms the result.
// One beat at a time, as the controller handles a single beat; the next beat is
// accepted in the cycle busy falls. done pulses that cycle after a last beat. Reset empties the set.
`timescale 1ns / 1ps

module sample_median #(
	parameter int CAPACITY = smed_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  smed_pkg::in_item_t item,
	output logic               done,
	output smed_pkg::result_t  result
);
	import smed_pkg::*;

	cmd_t    cmd;
	status_t status;

	smed_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	smed_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result),
		.done   (done)
	);

endmodule

// ===== src/smed_ctrl.sv =====
// smed_ctrl: sequencing state machine of the sample median block.
// Drives the datapath through smed_pkg command/status structs.
// Depends on smed_pkg.
`timescale 1ns / 1ps

module smed_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  smed_pkg::status_t status,
	output smed_pkg::cmd_t    cmd
);
	import smed_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHK   = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_MID_A = 3'd3;
	localparam logic [2:0] S_MID_B = 3'd4;
	localparam logic [2:0] S_MID_C = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				if (status.full) begin
					cmd.drop = 1'b1;
					state_d  = status.last ? S_MID_A : S_IDLE;
				end else if (status.idx_zero) begin
					cmd.place = 1'b1;
					state_d   = status.last ? S_MID_A : S_IDLE;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				if (status.gt) begin
					cmd.shift = 1'b1;
					state_d   = S_CHK;
				end else begin
					cmd.place = 1'b1;
					state_d   = status.last ? S_MID_A : S_IDLE;
				end
			end
			S_MID_A: begin
				cmd.rd_hi = 1'b1;
				state_d   = S_MID_B;
			end
			S_MID_B: begin
				cmd.rd_lo = 1'b1;
				state_d   = S_MID_C;
			end
			S_MID_C: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/smed_datapath.sv =====
// smed_datapath: sorted sample store, insertion pointer, fill count and median math.
// Store memory with a separate write port and a registered read port.
// Depends on smed_pkg.
`timescale 1ns / 1ps

module smed_datapath #(
	parameter int CAPACITY = smed_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smed_pkg::in_item_t item,
	input  smed_pkg::cmd_t     cmd,
	output smed_pkg::status_t  status,
	output smed_pkg::result_t  result,
	output logic               done
);
	import smed_pkg::*;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	logic signed [DATA_W-1:0] mem [CAPACITY];

	logic signed [DATA_W-1:0] x_q;
	logic                     last_q;
	logic [CNT_W-1:0]         idx_q;
	logic [CNT_W-1:0]         fill_q;
	logic                     ovf_q;
	logic signed [DATA_W-1:0] rdata_q;
	logic signed [DATA_W-1:0] hi_q;
	result_t                  result_q;
	logic                     done_q;

	logic [CNT_W-1:0]         mid_w;
	logic [CNT_W-1:0]         prev_w;
	logic [CNT_W-1:0]         mid_lo_w;
	logic [ADDR_W-1:0]        rd_addr;
	logic                     rd_en;
	logic                     we;
	logic signed [DATA_W-1:0] wdata;
	logic [DATA_W:0]          sum_w;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	assign mid_w    = fill_q >> 1;
	assign mid_lo_w = mid_w - CNT_W'(1);
	assign prev_w   = idx_q - CNT_W'(1);

	always_comb begin
		if (cmd.rd_hi) begin
			rd_addr = mid_w[ADDR_W-1:0];
		end else if (cmd.rd_lo) begin
			rd_addr = mid_lo_w[ADDR_W-1:0];
		end else begin
			rd_addr = prev_w[ADDR_W-1:0];
		end
	end

	assign rd_en = cmd.rd_prev | cmd.rd_hi | cmd.rd_lo;
	assign we    = cmd.shift | cmd.place;
	assign wdata = cmd.shift ? rdata_q : x_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx_q[ADDR_W-1:0]] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= item.sample;
			last_q <= item.last;
		end
		if (cmd.rd_lo) begin
			hi_q <= rdata_q;
		end
	end

	assign sum_w     = {hi_q[DATA_W-1], hi_q} + {rdata_q[DATA_W-1], rdata_q};
	assign count_ext = {{COUNT_W{1'b0}}, fill_q};

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.median_value <= fill_q[0] ? hi_q : sum_w[DATA_W:1];
			result_q.sample_count <= count_ext[COUNT_W-1:0];
			result_q.overflow     <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			fill_q <= '0;
			ovf_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				idx_q <= fill_q;
			end else if (cmd.shift) begin
				idx_q <= prev_w;
			end
			if (cmd.finish) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				if (cmd.place) begin
					fill_q <= fill_q + CNT_W'(1);
				end
				if (cmd.drop) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign status.full     = (fill_q == CNT_W'(CAPACITY));
	assign status.idx_zero = (idx_q == '0);
	assign status.gt       = (rdata_q > x_q);
	assign status.last     = last_q;

	assign result = result_q;
	assign done   = done_q;

endmodule

// ===== src/smed_checker.sv =====
// smed_checker: port-level temporal checks for sample_median, bound to the top level.
// Depends on smed_pkg.
`timescale 1ns / 1ps

module smed_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input smed_pkg::in_item_t item,
	input logic               done,
	input smed_pkg::result_t  result
);
	import smed_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without work in progress");

endmodule

bind sample_median smed_checker u_smed_checker (.*);
